FILE: hdl/bad_pkg.sv
// Shared types, widths and constants for the box average downscaler.
// No dependencies; every other file imports this package.
package bad_pkg;

  // Storage and field sizes
  localparam int unsigned MAX_DST_WIDTH = 512;
  localparam int unsigned PIXEL_BITS    = 8;
  localparam int unsigned ADDR_W        = $clog2(MAX_DST_WIDTH);
  localparam int unsigned SUM_W         = 12;
  localparam int unsigned COL_W         = 10;
  localparam int unsigned ROW_W         = 11;

  // Configuration register widths
  localparam int unsigned SCALE_W       = 3;
  localparam int unsigned SRC_W_W       = 11;
  localparam int unsigned SRC_H_W       = 12;
  localparam int unsigned DST_W_W       = 10;
  localparam int unsigned DST_H_W       = 11;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 12;
  localparam int unsigned COL_LIM_W     = 12;
  localparam int unsigned ROW_LIM_W     = 13;

  // Reciprocals: x/3 = (x*2731)>>13 for x < 2048, x/9 = (x*7282)>>16 for x < 4096
  localparam int unsigned RECIP3        = 2731;
  localparam int unsigned RECIP3_SH     = 13;
  localparam int unsigned RECIP9        = 7282;
  localparam int unsigned RECIP9_SH     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE      = 3'd0,
    REG_SRC_WIDTH  = 3'd1,
    REG_SRC_HEIGHT = 3'd2,
    REG_DST_WIDTH  = 3'd3,
    REG_DST_HEIGHT = 3'd4
  } cfg_reg_e;

  // Effective geometry after clamping
  typedef struct packed {
    logic [SCALE_W-1:0]   scale;
    logic [SRC_W_W-1:0]   src_w;
    logic [SRC_H_W-1:0]   src_h;
    logic [COL_LIM_W-1:0] col_lim;
    logic [ROW_LIM_W-1:0] row_lim;
  } geom_t;

  // Block decode of one source pixel
  typedef struct packed {
    logic              in_area;
    logic [ADDR_W-1:0] addr;
    logic              first;
    logic              emit;
    logic              last;
  } blk_t;

  // Finished block sum heading for the output stage
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [SUM_W-1:0] sum;
  } res_t;

endpackage

FILE: hdl/box_average_downscaler_core.sv
// Top level of the box average downscaler.
// Depends on bad_pkg, bad_cfg, bad_locate, bad_accum and bad_mean.
//
// Usage
//   Input channel: one 8-bit grayscale source pixel per request, raster order.
//   Output channel: one request per completed scale x scale block, carrying
//   the truncated block mean and a flag on the last block of the frame.
//   Pixels outside dst_width*scale columns or dst_height*scale rows are
//   consumed and produce nothing. Position counters wrap after the last
//   source pixel of a frame, so frames follow each other without gaps.
//   Configuration port: register index plus data, always ready; write only
//   while the pipeline is empty.
// Timing
//   Four-stage pipeline: decode, block-sum memory read, add and write back,
//   mean and output register. Throughput is one pixel per cycle while the
//   output is not stalled; a read/add/write to the same column entry in
//   consecutive cycles is served by a forwarding register, so no interlock
//   bubbles occur.
// Reset and stalls
//   Reset loads the default geometry (scale 2, 752x480 to 376x240) and zeroes
//   the position counters; the sum memory is not cleared, each block starts
//   by overwriting its entry. While a result waits untaken and another
//   result reaches the output stage, the whole pipeline holds and in_ready_o
//   drops; otherwise pixels keep flowing.
module box_average_downscaler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bad_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bad_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bad_pkg::PIXEL_BITS-1:0] pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bad_pkg::PIXEL_BITS-1:0] pixel_out_o,
  output logic                           frame_last_o
);
  import bad_pkg::*;

  geom_t                 geom;
  logic                  adv;
  logic                  v1;
  logic [PIXEL_BITS-1:0] pix1;
  blk_t                  blk;
  res_t                  res;

  // one enable for the decode, read and add stages; a request is taken whenever it is high
  assign in_ready_o = adv;

  bad_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  // stage 1: column/row counters and block decode
  bad_locate u_locate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .in_valid_i (in_valid_i),
    .pixel_in_i (pixel_in_i),
    .geom_i     (geom),
    .v1_o       (v1),
    .pix_o      (pix1),
    .blk_o      (blk)
  );

  // stages 2 and 3: sum memory read, accumulate, write back
  bad_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .v1_i   (v1),
    .pix_i  (pix1),
    .blk_i  (blk),
    .res_o  (res)
  );

  // stage 4: divide by scale squared into the output register
  bad_mean u_mean (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .scale_i      (geom.scale),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o),
    .adv_o        (adv)
  );

endmodule

FILE: hdl/bad_cfg.sv
// Configuration registers and clamped geometry for the downscaler.
// Depends on bad_pkg.
module bad_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bad_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bad_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bad_pkg::geom_t                 geom_o
);
  import bad_pkg::*;

  localparam logic [SCALE_W-1:0] RST_SCALE = 3'd2;
  localparam logic [SRC_W_W-1:0] RST_SRC_W = 11'd752;
  localparam logic [SRC_H_W-1:0] RST_SRC_H = 12'd480;
  localparam logic [DST_W_W-1:0] RST_DST_W = 10'd376;
  localparam logic [DST_H_W-1:0] RST_DST_H = 11'd240;

  logic [SCALE_W-1:0] scale_q;
  logic [SRC_W_W-1:0] src_width_q;
  logic [SRC_H_W-1:0] src_height_q;
  logic [DST_W_W-1:0] dst_width_q;
  logic [DST_H_W-1:0] dst_height_q;
  logic [DST_W_W-1:0] dw;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q      <= RST_SCALE;
      src_width_q  <= RST_SRC_W;
      src_height_q <= RST_SRC_H;
      dst_width_q  <= RST_DST_W;
      dst_height_q <= RST_DST_H;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SCALE:      scale_q      <= cfg_data_i[SCALE_W-1:0];
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SRC_W_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i[SRC_H_W-1:0];
        REG_DST_WIDTH:  dst_width_q  <= cfg_data_i[DST_W_W-1:0];
        REG_DST_HEIGHT: dst_height_q <= cfg_data_i[DST_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // scale held to 2..4
    if (scale_q < 3'd2) begin
      geom_o.scale = 3'd2;
    end else if (scale_q > 3'd4) begin
      geom_o.scale = 3'd4;
    end else begin
      geom_o.scale = scale_q;
    end
    if (src_width_q == '0) begin
      geom_o.src_w = 11'd1;
    end else if (src_width_q > 11'd1024) begin
      geom_o.src_w = 11'd1024;
    end else begin
      geom_o.src_w = src_width_q;
    end
    if (src_height_q == '0) begin
      geom_o.src_h = 12'd1;
    end else if (src_height_q > 12'd2048) begin
      geom_o.src_h = 12'd2048;
    end else begin
      geom_o.src_h = src_height_q;
    end
    if (32'(dst_width_q) > MAX_DST_WIDTH) begin
      dw = DST_W_W'(MAX_DST_WIDTH);
    end else begin
      dw = dst_width_q;
    end
    geom_o.col_lim = COL_LIM_W'(dw) * COL_LIM_W'(geom_o.scale);
    geom_o.row_lim = ROW_LIM_W'(dst_height_q) * ROW_LIM_W'(geom_o.scale);
  end

endmodule

FILE: hdl/bad_locate.sv
// Raster position counters and block decode of each accepted pixel.
// Depends on bad_pkg.
module bad_locate (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           in_valid_i,
  input  logic [bad_pkg::PIXEL_BITS-1:0] pixel_in_i,
  input  bad_pkg::geom_t                 geom_i,
  output logic                           v1_o,
  output logic [bad_pkg::PIXEL_BITS-1:0] pix_o,
  output bad_pkg::blk_t                  blk_o
);
  import bad_pkg::*;

  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [COL_W:0]        col_inc;
  logic [ROW_W:0]        row_inc;
  logic                  accept;
  logic                  v1_q;
  logic [PIXEL_BITS-1:0] pix1_q;
  logic [COL_W-1:0]      c1_q;
  logic [ROW_W-1:0]      r1_q;
  logic [ROW_W-1:0]      qc, qr;
  logic [ROW_W-1:0]      rem_c, rem_r;
  logic [1:0]            s_m1;

  // quotient by 2, 3 or 4; 3 by reciprocal multiply
  function automatic logic [ROW_W-1:0] div_s(input logic [ROW_W-1:0] x,
                                             input logic [SCALE_W-1:0] s);
    logic [ROW_W+RECIP3_SH-1:0] p;
    p = (ROW_W+RECIP3_SH)'(x) * (ROW_W+RECIP3_SH)'(RECIP3);
    case (s)
      3'd2:    return x >> 1;
      3'd4:    return x >> 2;
      default: return ROW_W'(p >> RECIP3_SH);
    endcase
  endfunction

  assign accept = en_i & in_valid_i;

  always_comb begin
    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    col_d   = col_q;
    row_d   = row_q;
    if (col_inc >= geom_i.src_w) begin
      col_d = '0;
      if (row_inc >= geom_i.src_h) begin
        row_d = '0;
      end else begin
        row_d = row_inc[ROW_W-1:0];
      end
    end else begin
      col_d = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (en_i) begin
        v1_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q <= pixel_in_i;
      c1_q   <= col_q;
      r1_q   <= row_q;
    end
  end

  always_comb begin
    qc    = div_s(ROW_W'(c1_q), geom_i.scale);
    qr    = div_s(r1_q, geom_i.scale);
    rem_c = ROW_W'(c1_q) - ROW_W'(qc * ROW_W'(geom_i.scale));
    rem_r = r1_q - ROW_W'(qr * ROW_W'(geom_i.scale));
    s_m1  = 2'(geom_i.scale - 3'd1);

    blk_o.in_area = (COL_LIM_W'(c1_q) < geom_i.col_lim) &&
                    (ROW_LIM_W'(r1_q) < geom_i.row_lim);
    blk_o.addr    = ADDR_W'(qc);
    blk_o.first   = (rem_c[1:0] == 2'd0) && (rem_r[1:0] == 2'd0);
    blk_o.emit    = (rem_c[1:0] == s_m1) && (rem_r[1:0] == s_m1);
    blk_o.last    = (COL_LIM_W'(c1_q) == geom_i.col_lim - 1'b1) &&
                    (ROW_LIM_W'(r1_q) == geom_i.row_lim - 1'b1);
  end

  assign v1_o  = v1_q;
  assign pix_o = pix1_q;

endmodule

FILE: hdl/bad_accum.sv
// Column block-sum memory: read, add, write back, with one-deep forwarding.
// Depends on bad_pkg.
module bad_accum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           v1_i,
  input  logic [bad_pkg::PIXEL_BITS-1:0] pix_i,
  input  bad_pkg::blk_t                  blk_i,
  output bad_pkg::res_t                  res_o
);
  import bad_pkg::*;

  logic [SUM_W-1:0]      mem [MAX_DST_WIDTH];
  logic [SUM_W-1:0]      rd_q;
  logic                  fwd_hit_q;
  logic [SUM_W-1:0]      fwd_data_q;
  logic                  v2_q;
  logic [ADDR_W-1:0]     bc2_q;
  logic [PIXEL_BITS-1:0] pix2_q;
  logic                  first2_q, emit2_q, last2_q;
  logic [SUM_W-1:0]      prev, sum2;
  logic                  wr_en;
  logic                  v3_q, last3_q;
  logic [SUM_W-1:0]      sum3_q;

  assign wr_en = en_i & v2_q;

  // the entry written at the read edge is still in flight: take it from fwd
  always_comb begin
    prev = fwd_hit_q ? fwd_data_q : rd_q;
    if (first2_q) begin
      sum2 = SUM_W'(pix2_q);
    end else begin
      sum2 = prev + SUM_W'(pix2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[bc2_q] <= sum2;
    end
    if (en_i && v1_i && blk_i.in_area) begin
      rd_q <= mem[blk_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
    end else if (en_i) begin
      fwd_hit_q <= wr_en && (blk_i.addr == bc2_q);
      v2_q      <= v1_i && blk_i.in_area;
      v3_q      <= v2_q && emit2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fwd_data_q <= sum2;
      bc2_q      <= blk_i.addr;
      pix2_q     <= pix_i;
      first2_q   <= blk_i.first;
      emit2_q    <= blk_i.emit;
      last2_q    <= blk_i.last;
      sum3_q     <= sum2;
      last3_q    <= last2_q;
    end
  end

  assign res_o.valid = v3_q;
  assign res_o.last  = last3_q;
  assign res_o.sum   = sum3_q;

`ifndef SYNTHESIS
  a_fwd_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && v1_i && blk_i.in_area && v2_q && (blk_i.addr == bc2_q) |=> fwd_hit_q)
    else $error("same-entry write not captured for forwarding");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(v2_q) && $stable(v3_q) && $stable(fwd_hit_q))
    else $error("pipeline moved while stalled");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && last2_q |-> emit2_q)
    else $error("frame end flagged on a pixel that closes no block");
`endif

endmodule

FILE: hdl/bad_mean.sv
// Block mean (divide by scale squared) and the output register.
// Depends on bad_pkg.
module bad_mean (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bad_pkg::res_t                  res_i,
  input  logic [bad_pkg::SCALE_W-1:0]    scale_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [bad_pkg::PIXEL_BITS-1:0] pixel_out_o,
  output logic                           frame_last_o,
  output logic                           adv_o
);
  import bad_pkg::*;

  localparam int unsigned PROD_W = SUM_W + RECIP9_SH;

  logic                  out_valid_q;
  logic [PIXEL_BITS-1:0] pixel_out_q;
  logic                  frame_last_q;
  logic                  load;
  logic [PROD_W-1:0]     p9;
  logic [PIXEL_BITS-1:0] mean;

  assign load  = !out_valid_q || out_ready_i;
  // hold everything only when a new result meets an untaken one
  assign adv_o = load || !res_i.valid;

  always_comb begin
    p9 = PROD_W'(res_i.sum) * PROD_W'(RECIP9);
    case (scale_i)
      3'd2:    mean = PIXEL_BITS'(res_i.sum >> 2);
      3'd4:    mean = PIXEL_BITS'(res_i.sum >> 4);
      default: mean = PIXEL_BITS'(p9 >> RECIP9_SH);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && res_i.valid) begin
      pixel_out_q  <= mean;
      frame_last_q <= res_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign frame_last_o = frame_last_q;

endmodule
